/* rtl/fpfa_pkg.sv */
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared types and fixed field widths for the fixed-partition fit allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    // fixed field widths of the item ports
    localparam int OP_W    = 2;
    localparam int BIDX_W  = 4;
    localparam int FSIZE_W = 16;
    localparam int TAG_W   = 8;
    localparam int TOT_W   = 20;
    localparam int WAIT_W  = 16;
    localparam int MODE_W  = 2;

    // saturation limits of the running totals
    localparam logic [TOT_W-1:0]  TOTAL_MAX = {TOT_W{1'b1}};
    localparam logic [WAIT_W-1:0] WAIT_MAX  = {WAIT_W{1'b1}};

    // item operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_REQ   = 2'd1,
        OP_QUERY = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // allocation policy codes
    typedef enum logic [MODE_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_NEXT  = 2'd1,
        FIT_BEST  = 2'd2,
        FIT_WORST = 2'd3
    } t_fit_mode;

endpackage

/* rtl/fpfa_ram.sv */
// ----------------------------------------------------------------------------
// fpfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fpfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/fpfa_fit_unit.sv */
// ----------------------------------------------------------------------------
// fpfa_fit_unit
// Shared fit compare: checks one candidate partition against the request and
// the best choice so far under the active policy.
// ----------------------------------------------------------------------------
module fpfa_fit_unit #(
    parameter int SIZE_BITS = 16
) (
    input  fpfa_pkg::t_fit_mode   i_mode,
    input  logic                  i_qualify,
    input  logic [SIZE_BITS-1:0]  i_size,
    input  logic [SIZE_BITS-1:0]  i_need,
    input  logic                  i_found,
    input  logic [SIZE_BITS-1:0]  i_best_left,
    output logic                  o_take,
    output logic [SIZE_BITS-1:0]  o_left
);
    import fpfa_pkg::*;

    logic fits;
    logic better;

    // size check and leftover
    assign fits   = i_qualify && (i_size >= i_need);
    assign o_left = i_size - i_need;

    // policy compare against the running best
    always_comb begin
        case (i_mode)
            FIT_BEST:  better = (o_left < i_best_left);
            FIT_WORST: better = (o_left > i_best_left);
            default:   better = 1'b0;
        endcase
    end

    assign o_take = fits && (!i_found || better);

endmodule

/* rtl/fixed_partition_fit_allocator.sv */
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator
// Table of fixed partitions with first, next, best and worst fit allocation.
// ----------------------------------------------------------------------------
// One item is taken at a time; o_in_ready is high only while the sequencer is
// idle. A load reads the old size and then writes the partition, a query reads
// the entry and then forms its fields, and a no operation goes straight to done.
// A request walks the size memory one partition per cycle through the shared
// fit compare, starting at the next-fit pointer in next fit mode and at 0
// otherwise, and then commits in the grant state. A finished result sits in the output
// register; the next item is taken while it waits. Sizes are held at
// SIZE_BITS bits; the external total is kept exact and clamped at the port.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [fpfa_pkg::MODE_W-1:0]     i_cfg_wdata,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [fpfa_pkg::OP_W-1:0]       i_op,
    input  logic [fpfa_pkg::BIDX_W-1:0]     i_block_index,
    input  logic [fpfa_pkg::FSIZE_W-1:0]    i_block_size,
    input  logic [fpfa_pkg::FSIZE_W-1:0]    i_request_size,
    input  logic [fpfa_pkg::TAG_W-1:0]      i_request_tag,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_granted,
    output logic [fpfa_pkg::BIDX_W-1:0]     o_chosen_block,
    output logic [fpfa_pkg::FSIZE_W-1:0]    o_leftover,
    output logic                            o_entry_allocated,
    output logic [fpfa_pkg::TAG_W-1:0]      o_entry_tag,
    output logic [fpfa_pkg::FSIZE_W-1:0]    o_entry_size,
    output logic [fpfa_pkg::TOT_W-1:0]      o_internal_total,
    output logic [fpfa_pkg::TOT_W-1:0]      o_external_total,
    output logic [fpfa_pkg::WAIT_W-1:0]     o_waiting_count
);
    import fpfa_pkg::*;

    localparam int IDX_W  = $clog2(NUM_BLOCKS);
    localparam int PTR_W  = IDX_W + 1;
    localparam int FREE_W = SIZE_BITS + IDX_W + 1;
    localparam int CMP_W  = (FREE_W > TOT_W) ? FREE_W : TOT_W;
    localparam int FRG_W  = TOT_W + 1;
    localparam int EXT_W  = (BIDX_W > PTR_W) ? BIDX_W + 1 : PTR_W + 1;
    localparam logic [PTR_W-1:0] PTR_END = PTR_W'(NUM_BLOCKS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_Q_RD,
        S_Q_OUT,
        S_SCAN,
        S_GRANT,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration and persistent state
    t_fit_mode              r_fit_mode;
    logic [NUM_BLOCKS-1:0]  r_present;
    logic [NUM_BLOCKS-1:0]  r_taken;
    logic [IDX_W-1:0]       r_start;
    logic [TOT_W-1:0]       r_frag;
    logic [FREE_W-1:0]      r_free;
    logic [WAIT_W-1:0]      r_wait;

    // latched item
    logic [IDX_W-1:0]       r_idx;
    logic [SIZE_BITS-1:0]   r_bsize;
    logic [SIZE_BITS-1:0]   r_need;
    logic [TAG_W-1:0]       r_tag;

    // scan state
    logic [PTR_W-1:0]       r_ptr;
    logic                   r_cmp_vld;
    logic [IDX_W-1:0]       r_cmp_idx;
    logic                   r_found;
    logic [IDX_W-1:0]       r_best_idx;
    logic [SIZE_BITS-1:0]   r_best_left;
    logic [SIZE_BITS-1:0]   r_best_size;

    // result fields before the output register
    logic                   r_res_grant;
    logic [BIDX_W-1:0]      r_res_chosen;
    logic [FSIZE_W-1:0]     r_res_left;
    logic                   r_res_alloc;
    logic [TAG_W-1:0]       r_res_tag;
    logic [FSIZE_W-1:0]     r_res_size;

    // memory and compare wiring
    logic                   size_we;
    logic [IDX_W-1:0]       size_waddr;
    logic [SIZE_BITS-1:0]   size_wdata;
    logic                   own_we;
    logic [IDX_W-1:0]       own_waddr;
    logic [TAG_W-1:0]       own_wdata;
    logic [IDX_W-1:0]       rd_addr;
    logic [SIZE_BITS-1:0]   size_rdata;
    logic [TAG_W-1:0]       own_rdata;
    logic                   fit_take;
    logic [SIZE_BITS-1:0]   fit_left;
    logic                   fit_qualify;

    // derived values
    logic                   in_beat;
    logic [EXT_W-1:0]       in_idx_ext;
    logic                   in_range;
    logic [CMP_W-1:0]       free_ext;
    logic [TOT_W-1:0]       free_clamp;
    logic [FRG_W-1:0]       frag_sum;
    logic [FREE_W-1:0]      old_free_part;
    logic [FREE_W-1:0]      n_free_load;

    assign in_beat    = i_in_valid && o_in_ready;
    assign in_idx_ext = EXT_W'(i_block_index);
    assign in_range   = (in_idx_ext < EXT_W'(NUM_BLOCKS));

    // external total clamp
    assign free_ext   = CMP_W'(r_free);
    assign free_clamp = (free_ext > CMP_W'(TOTAL_MAX)) ? TOTAL_MAX : TOT_W'(free_ext);

    // internal total with saturation
    assign frag_sum = FRG_W'(r_frag) + FRG_W'(r_best_left);

    // free total update for a load: drop old free size, add new one
    assign old_free_part = (r_present[r_idx] && !r_taken[r_idx]) ?
                           FREE_W'(size_rdata) : '0;
    assign n_free_load   = r_free - old_free_part + FREE_W'(r_bsize);

    assign fit_qualify = r_cmp_vld && r_present[r_cmp_idx] && !r_taken[r_cmp_idx];

    // memory port control
    always_comb begin
        size_we    = 1'b0;
        size_waddr = r_idx;
        size_wdata = r_bsize;
        own_we     = 1'b0;
        own_waddr  = r_idx;
        own_wdata  = '0;
        rd_addr    = r_idx;
        case (r_state)
            S_LD_WR: begin
                size_we = 1'b1;
                own_we  = 1'b1;
            end
            S_SCAN: begin
                rd_addr = r_ptr[IDX_W-1:0];
            end
            S_GRANT: begin
                own_we    = r_found;
                own_waddr = r_best_idx;
                own_wdata = r_tag;
            end
            default: begin
                rd_addr = r_idx;
            end
        endcase
    end

    fpfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (size_we),
        .i_waddr (size_waddr),
        .i_wdata (size_wdata),
        .i_raddr (rd_addr),
        .o_rdata (size_rdata)
    );

    fpfa_ram #(
        .WIDTH (TAG_W),
        .DEPTH (NUM_BLOCKS)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (own_we),
        .i_waddr (own_waddr),
        .i_wdata (own_wdata),
        .i_raddr (rd_addr),
        .o_rdata (own_rdata)
    );

    fpfa_fit_unit #(
        .SIZE_BITS (SIZE_BITS)
    ) u_fit (
        .i_mode      (r_fit_mode),
        .i_qualify   (fit_qualify),
        .i_size      (size_rdata),
        .i_need      (r_need),
        .i_found     (r_found),
        .i_best_left (r_best_left),
        .o_take      (fit_take),
        .o_left      (fit_left)
    );

    // sequencer, table marks, totals and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fit_mode  <= FIT_FIRST;
            r_present   <= '0;
            r_taken     <= '0;
            r_start     <= '0;
            r_frag      <= '0;
            r_free      <= '0;
            r_wait      <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            o_in_ready  <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            // configuration write
            if (i_cfg_we) begin
                r_fit_mode <= t_fit_mode'(i_cfg_wdata);
            end

            // output beat taken, refilled from the done state
            if (o_out_valid && i_out_ready && (r_state != S_DONE)) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        o_in_ready   <= 1'b0;
                        r_idx        <= in_idx_ext[IDX_W-1:0];
                        r_bsize      <= SIZE_BITS'(i_block_size);
                        r_need       <= SIZE_BITS'(i_request_size);
                        r_tag        <= i_request_tag;
                        r_res_grant  <= 1'b0;
                        r_res_chosen <= '0;
                        r_res_left   <= '0;
                        r_res_alloc  <= 1'b0;
                        r_res_tag    <= '0;
                        r_res_size   <= '0;
                        r_found      <= 1'b0;
                        r_best_left  <= '0;
                        r_cmp_vld    <= 1'b0;
                        r_ptr        <= (r_fit_mode == FIT_NEXT) ? PTR_W'(r_start) : '0;
                        case (t_op'(i_op))
                            OP_LOAD:  r_state <= in_range ? S_LD_RD : S_DONE;
                            OP_REQ:   r_state <= S_SCAN;
                            OP_QUERY: r_state <= in_range ? S_Q_RD : S_DONE;
                            default:  r_state <= S_DONE;
                        endcase
                    end else begin
                        o_in_ready <= 1'b1;
                    end
                end

                // old size read for the free total
                S_LD_RD: begin
                    r_state <= S_LD_WR;
                end

                S_LD_WR: begin
                    r_free           <= n_free_load;
                    r_present[r_idx] <= 1'b1;
                    r_taken[r_idx]   <= 1'b0;
                    r_state          <= S_DONE;
                end

                S_Q_RD: begin
                    r_state <= S_Q_OUT;
                end

                // entries never loaded read as zero
                S_Q_OUT: begin
                    r_res_alloc <= r_taken[r_idx];
                    r_res_tag   <= r_present[r_idx] ? own_rdata : '0;
                    r_res_size  <= r_present[r_idx] ? FSIZE_W'(size_rdata) : '0;
                    r_state     <= S_DONE;
                end

                // one partition per cycle through the fit compare
                S_SCAN: begin
                    if (r_ptr != PTR_END) begin
                        r_cmp_vld <= 1'b1;
                        r_cmp_idx <= r_ptr[IDX_W-1:0];
                        r_ptr     <= r_ptr + PTR_W'(1);
                    end else begin
                        r_cmp_vld <= 1'b0;
                        r_state   <= S_GRANT;
                    end
                    if (fit_take) begin
                        r_found     <= 1'b1;
                        r_best_idx  <= r_cmp_idx;
                        r_best_left <= fit_left;
                        r_best_size <= size_rdata;
                    end
                end

                // commit the grant or count the miss
                S_GRANT: begin
                    if (r_found) begin
                        r_taken[r_best_idx] <= 1'b1;
                        r_free              <= r_free - FREE_W'(r_best_size);
                        r_frag              <= (frag_sum > FRG_W'(TOTAL_MAX)) ?
                                               TOTAL_MAX : TOT_W'(frag_sum);
                        if (r_fit_mode == FIT_NEXT) begin
                            r_start <= r_best_idx;
                        end
                        r_res_grant  <= 1'b1;
                        r_res_chosen <= BIDX_W'(r_best_idx);
                        r_res_left   <= FSIZE_W'(r_best_left);
                    end else if (r_wait != WAIT_MAX) begin
                        r_wait <= r_wait + WAIT_W'(1);
                    end
                    r_state <= S_DONE;
                end

                // hand the result to the output register
                S_DONE: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid       <= 1'b1;
                        o_granted         <= r_res_grant;
                        o_chosen_block    <= r_res_chosen;
                        o_leftover        <= r_res_left;
                        o_entry_allocated <= r_res_alloc;
                        o_entry_tag       <= r_res_tag;
                        o_entry_size      <= r_res_size;
                        o_internal_total  <= r_frag;
                        o_external_total  <= free_clamp;
                        o_waiting_count   <= r_wait;
                        o_in_ready        <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* tb/fixed_partition_fit_allocator_tb.sv */
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_tb
// Self-checking bench for the fixed-partition fit allocator. A scoreboard
// class keeps its own copy of the partition table, the policy and the
// running totals. It works out the report for every accepted item and
// compares each returned report against the oldest one still owed. A short
// directed run covers every policy and the edge sizes. Random traffic then
// runs in phases, one policy per phase, with random stalls on both sides,
// one long output hold-off and one full drain in the middle of a phase.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_tb;
    import fpfa_pkg::*;

    localparam int NUM_PARTS    = 16;
    localparam int SETTLE_CYC   = 24;
    localparam int LONG_HOLD    = 160;
    localparam int PHASE_ITEMS  = 300;
    localparam int NUM_PHASES   = 6;

    // one input beat
    typedef struct packed {
        t_op                op;
        logic [BIDX_W-1:0]  index;
        logic [FSIZE_W-1:0] part_bytes;
        logic [FSIZE_W-1:0] need;
        logic [TAG_W-1:0]   tag;
    } t_fit_item;

    // one result beat
    typedef struct packed {
        logic               granted;
        logic [BIDX_W-1:0]  chosen;
        logic [FSIZE_W-1:0] leftover;
        logic               entry_taken;
        logic [TAG_W-1:0]   entry_tag;
        logic [FSIZE_W-1:0] entry_bytes;
        logic [TOT_W-1:0]   frag_total;
        logic [TOT_W-1:0]   free_total;
        logic [WAIT_W-1:0]  wait_total;
    } t_fit_report;

    // shadow partition table and owed reports
    class fit_table_scoreboard;
        t_fit_mode          mode;
        logic [FSIZE_W-1:0] part_bytes [NUM_PARTS];
        bit                 part_here  [NUM_PARTS];
        bit                 part_taken [NUM_PARTS];
        logic [TAG_W-1:0]   part_owner [NUM_PARTS];
        logic [BIDX_W-1:0]  next_from;
        logic [TOT_W-1:0]   frag_sum;
        logic [TOT_W-1:0]   free_sum;
        logic [WAIT_W-1:0]  wait_sum;
        t_fit_report        owed_reports [$];
        int                 bad_count;

        function new();
            mode      = FIT_FIRST;
            next_from = '0;
            frag_sum  = '0;
            free_sum  = '0;
            wait_sum  = '0;
            bad_count = 0;
            for (int k = 0; k < NUM_PARTS; k++) begin
                part_bytes[k] = '0;
                part_here[k]  = 1'b0;
                part_taken[k] = 1'b0;
                part_owner[k] = '0;
            end
        endfunction

        // apply one accepted item to the table and queue the report it owes
        function void apply_item(t_fit_item it);
            t_fit_report        rep;
            int                 pick;
            int                 from;
            logic [FSIZE_W-1:0] left;
            logic [FSIZE_W-1:0] pick_left;
            longint             acc;
            rep       = '0;
            pick      = -1;
            pick_left = '0;
            case (it.op)
                OP_LOAD: begin
                    part_bytes[it.index] = it.part_bytes;
                    part_here[it.index]  = 1'b1;
                    part_taken[it.index] = 1'b0;
                    part_owner[it.index] = '0;
                end
                OP_REQ: begin
                    from = (mode == FIT_NEXT) ? int'(next_from) : 0;
                    for (int k = from; k < NUM_PARTS; k++) begin
                        if (part_here[k] && !part_taken[k] && part_bytes[k] >= it.need) begin
                            left = part_bytes[k] - it.need;
                            if (mode == FIT_FIRST || mode == FIT_NEXT) begin
                                if (pick < 0) begin
                                    pick      = k;
                                    pick_left = left;
                                end
                            end else if (pick < 0 ||
                                         (mode == FIT_BEST && left < pick_left) ||
                                         (mode == FIT_WORST && left > pick_left)) begin
                                pick      = k;
                                pick_left = left;
                            end
                        end
                    end
                    if (pick >= 0) begin
                        part_taken[pick] = 1'b1;
                        part_owner[pick] = it.tag;
                        rep.granted      = 1'b1;
                        rep.chosen       = pick[BIDX_W-1:0];
                        rep.leftover     = pick_left;
                        acc = longint'(frag_sum) + longint'(pick_left);
                        frag_sum = (acc > longint'(TOTAL_MAX)) ? TOTAL_MAX : acc[TOT_W-1:0];
                        if (mode == FIT_NEXT)
                            next_from = pick[BIDX_W-1:0];
                    end else if (wait_sum != WAIT_MAX) begin
                        wait_sum = wait_sum + 1'b1;
                    end
                end
                OP_QUERY: begin
                    rep.entry_taken = part_taken[it.index];
                    rep.entry_tag   = part_owner[it.index];
                    rep.entry_bytes = part_bytes[it.index];
                end
                default: begin
                end
            endcase
            // free total over present untaken partitions
            acc = 0;
            for (int k = 0; k < NUM_PARTS; k++) begin
                if (part_here[k] && !part_taken[k])
                    acc += longint'(part_bytes[k]);
            end
            free_sum = (acc > longint'(TOTAL_MAX)) ? TOTAL_MAX : acc[TOT_W-1:0];
            rep.frag_total = frag_sum;
            rep.free_total = free_sum;
            rep.wait_total = wait_sum;
            owed_reports.push_back(rep);
        endfunction

        function string describe(t_fit_report r);
            return $sformatf("g=%0d blk=%0d left=%0d tk=%0d tag=%0d sz=%0d int=%0d ext=%0d wt=%0d",
                             r.granted, r.chosen, r.leftover, r.entry_taken, r.entry_tag,
                             r.entry_bytes, r.frag_total, r.free_total, r.wait_total);
        endfunction

        // compare one returned report with the oldest owed one
        function void match_report(t_fit_report got);
            t_fit_report want;
            bit          wrong;
            if (owed_reports.size() == 0) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("mismatch: result beat with nothing owed: %s", describe(got));
                return;
            end
            want  = owed_reports.pop_front();
            wrong = (got.granted !== want.granted) || (got.chosen !== want.chosen) ||
                    (got.leftover !== want.leftover) ||
                    (got.entry_taken !== want.entry_taken) ||
                    (got.entry_tag !== want.entry_tag) ||
                    (got.entry_bytes !== want.entry_bytes) ||
                    (got.frag_total !== want.frag_total) ||
                    (got.free_total !== want.free_total) ||
                    (got.wait_total !== want.wait_total);
            if (wrong) begin
                bad_count++;
                if (bad_count <= 10) begin
                    $display("mismatch: expected %s", describe(want));
                    $display("mismatch: actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [MODE_W-1:0]   i_cfg_wdata;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [OP_W-1:0]     i_op;
    logic [BIDX_W-1:0]   i_block_index;
    logic [FSIZE_W-1:0]  i_block_size;
    logic [FSIZE_W-1:0]  i_request_size;
    logic [TAG_W-1:0]    i_request_tag;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_granted;
    logic [BIDX_W-1:0]   o_chosen_block;
    logic [FSIZE_W-1:0]  o_leftover;
    logic                o_entry_allocated;
    logic [TAG_W-1:0]    o_entry_tag;
    logic [FSIZE_W-1:0]  o_entry_size;
    logic [TOT_W-1:0]    o_internal_total;
    logic [TOT_W-1:0]    o_external_total;
    logic [WAIT_W-1:0]   o_waiting_count;

    fit_table_scoreboard sb = new();
    bit                  calm = 1'b0;
    bit                  long_hold = 1'b0;

    fixed_partition_fit_allocator #(
        .NUM_BLOCKS (NUM_PARTS),
        .SIZE_BITS  (16)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_block_index     (i_block_index),
        .i_block_size      (i_block_size),
        .i_request_size    (i_request_size),
        .i_request_tag     (i_request_tag),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_granted         (o_granted),
        .o_chosen_block    (o_chosen_block),
        .o_leftover        (o_leftover),
        .o_entry_allocated (o_entry_allocated),
        .o_entry_tag       (o_entry_tag),
        .o_entry_size      (o_entry_size),
        .o_internal_total  (o_internal_total),
        .o_external_total  (o_external_total),
        .o_waiting_count   (o_waiting_count)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // beat monitor: check results first, then note the accepted input
    always @(posedge i_clk) begin
        t_fit_item   seen;
        t_fit_report got;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got.granted     = o_granted;
                got.chosen      = o_chosen_block;
                got.leftover    = o_leftover;
                got.entry_taken = o_entry_allocated;
                got.entry_tag   = o_entry_tag;
                got.entry_bytes = o_entry_size;
                got.frag_total  = o_internal_total;
                got.free_total  = o_external_total;
                got.wait_total  = o_waiting_count;
                sb.match_report(got);
            end
            if (i_in_valid && o_in_ready) begin
                seen.op         = t_op'(i_op);
                seen.index      = i_block_index;
                seen.part_bytes = i_block_size;
                seen.need       = i_request_size;
                seen.tag        = i_request_tag;
                sb.apply_item(seen);
            end
        end
    end

    // output side: random stall bursts and one long hold-off
    initial begin : out_side
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold = 1'b0;
                i_out_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic t_fit_item make_item(t_op op, int idx, int bytes, int need, int tag);
        t_fit_item it;
        it.op         = op;
        it.index      = idx[BIDX_W-1:0];
        it.part_bytes = bytes[FSIZE_W-1:0];
        it.need       = need[FSIZE_W-1:0];
        it.tag        = tag[TAG_W-1:0];
        return it;
    endfunction

    function automatic logic [FSIZE_W-1:0] random_bytes();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return FSIZE_W'($urandom_range(0, 65535));
            default: return FSIZE_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // random item, requests partly sized against the current table
    function automatic t_fit_item random_item();
        t_fit_item          it;
        int                 roll;
        logic [FSIZE_W-1:0] ref_bytes;
        it.index      = BIDX_W'($urandom_range(0, NUM_PARTS - 1));
        it.part_bytes = random_bytes();
        it.need       = random_bytes();
        it.tag        = TAG_W'($urandom_range(0, 255));
        roll          = $urandom_range(0, 99);
        if (roll < 32)
            it.op = OP_LOAD;
        else if (roll < 76)
            it.op = OP_REQ;
        else if (roll < 95)
            it.op = OP_QUERY;
        else
            it.op = OP_NOP;
        if (it.op == OP_REQ) begin
            ref_bytes = sb.part_bytes[$urandom_range(0, NUM_PARTS - 1)];
            case ($urandom_range(0, 3))
                0: it.need = ref_bytes;
                1: it.need = (ref_bytes > 16'd300) ? ref_bytes - FSIZE_W'($urandom_range(0, 300))
                                                   : FSIZE_W'($urandom_range(0, 300));
                2: it.need = FSIZE_W'($urandom_range(0, 255));
                default: begin
                end
            endcase
        end
        return it;
    endfunction

    // offer one beat and hold it until accepted, then maybe idle
    task automatic send_item(t_fit_item it);
        i_in_valid     <= 1'b1;
        i_op           <= it.op;
        i_block_index  <= it.index;
        i_block_size   <= it.part_bytes;
        i_request_size <= it.need;
        i_request_tag  <= it.tag;
        do @(posedge i_clk); while (!o_in_ready);
        if (!calm && !long_hold && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every owed report has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.owed_reports.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // policy register write, only while the block is idle
    task automatic write_mode(t_fit_mode m);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.mode = m;
    endtask

    // run limit
    initial begin : watchdog
        #1000000;
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        t_fit_mode phase_mode [NUM_PHASES];
        phase_mode = '{FIT_NEXT, FIT_BEST, FIT_WORST, FIT_FIRST, FIT_NEXT, FIT_BEST};
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        i_in_valid     <= 1'b0;
        i_op           <= '0;
        i_block_index  <= '0;
        i_block_size   <= '0;
        i_request_size <= '0;
        i_request_tag  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // first fit: empty table, zero sizes, full-size partition
        write_mode(FIT_FIRST);
        send_item(make_item(OP_QUERY, 0, 0, 0, 0));
        send_item(make_item(OP_REQ, 0, 0, 0, 8'h11));
        send_item(make_item(OP_LOAD, 0, 0, 0, 0));
        send_item(make_item(OP_LOAD, 15, 65535, 0, 0));
        send_item(make_item(OP_LOAD, 5, 100, 0, 0));
        send_item(make_item(OP_LOAD, 7, 100, 0, 0));
        send_item(make_item(OP_LOAD, 3, 300, 0, 0));
        send_item(make_item(OP_REQ, 0, 0, 0, 8'hff));
        send_item(make_item(OP_REQ, 0, 0, 65535, 8'h5a));
        send_item(make_item(OP_REQ, 0, 0, 65535, 8'h33));
        send_item(make_item(OP_QUERY, 15, 0, 0, 0));
        send_item(make_item(OP_NOP, 9, 1234, 4321, 8'h77));

        // best fit: tie between two equal partitions goes low
        drain();
        write_mode(FIT_BEST);
        send_item(make_item(OP_REQ, 0, 0, 50, 8'h01));
        send_item(make_item(OP_REQ, 0, 0, 50, 8'h02));
        send_item(make_item(OP_LOAD, 5, 100, 0, 0));

        // worst fit: largest leftover, then a tie
        drain();
        write_mode(FIT_WORST);
        send_item(make_item(OP_LOAD, 9, 100, 0, 0));
        send_item(make_item(OP_REQ, 0, 0, 10, 8'h03));
        send_item(make_item(OP_REQ, 0, 0, 10, 8'h04));

        // next fit: grant moves the pointer, failed search leaves it
        drain();
        write_mode(FIT_NEXT);
        send_item(make_item(OP_REQ, 0, 0, 1, 8'h05));
        send_item(make_item(OP_LOAD, 2, 500, 0, 0));
        send_item(make_item(OP_REQ, 0, 0, 1, 8'h06));
        send_item(make_item(OP_QUERY, 2, 0, 0, 0));
        send_item(make_item(OP_QUERY, 9, 0, 0, 0));

        // random phases, one policy each, the last one with no idling
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            write_mode(phase_mode[ph]);
            if (ph == NUM_PHASES - 1)
                calm = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == 40)
                    long_hold = 1'b1;
                if (ph == 3 && n == 150)
                    drain();
                send_item(random_item());
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (sb.bad_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
